### src/mit_command_frame_packer_assert.svh
// Assertion macros shared by the command frame packer RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef MIT_COMMAND_FRAME_PACKER_ASSERT_SVH
`define MIT_COMMAND_FRAME_PACKER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define MCFP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only.
`define MCFP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mcfp_pkg.sv
// Package for the command frame packer: widths, register indexes, reset values.
// No dependencies.
`default_nettype none
package mcfp_pkg;
	localparam int CMD_W   = 32;   // Q16.16 command word
	localparam int LIMIT_W = 31;   // configuration register width
	localparam int HW      = 47;   // half divisor width (limit << 16)
	localparam int AW      = 48;   // dividend operand width
	localparam int INDEX_W = 3;

	localparam logic [INDEX_W-1:0] REG_POSITION_LIMIT  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_VELOCITY_LIMIT  = 3'd1;
	localparam logic [INDEX_W-1:0] REG_TORQUE_LIMIT    = 3'd2;
	localparam logic [INDEX_W-1:0] REG_STIFFNESS_LIMIT = 3'd3;
	localparam logic [INDEX_W-1:0] REG_DAMPING_LIMIT   = 3'd4;
	localparam logic [INDEX_W-1:0] REG_GEAR_RATIO      = 3'd5;
	localparam logic [INDEX_W-1:0] REG_REVERSE         = 3'd6;

	localparam logic [LIMIT_W-1:0] RST_POSITION_LIMIT  = 31'd819200;
	localparam logic [LIMIT_W-1:0] RST_VELOCITY_LIMIT  = 31'd1966080;
	localparam logic [LIMIT_W-1:0] RST_TORQUE_LIMIT    = 31'd655360;
	localparam logic [LIMIT_W-1:0] RST_STIFFNESS_LIMIT = 31'd32768000;
	localparam logic [LIMIT_W-1:0] RST_DAMPING_LIMIT   = 31'd327680;
	localparam logic [LIMIT_W-1:0] RST_GEAR_RATIO      = 31'd65536;
	localparam logic [LIMIT_W-1:0] UNITY_RATIO         = 31'd65536;
endpackage
`default_nettype wire

### src/mcfp_sgn_front.sv
// Front end for a signed lane: ratio multiply, reverse, clamp, offset by limit.
// Uses mcfp_pkg. Four register stages.
`default_nettype none
module mcfp_sgn_front (
	input  wire logic                          clk,
	input  wire logic [3:0]                    en,
	input  wire logic [mcfp_pkg::CMD_W-1:0]    value,
	input  wire logic [mcfp_pkg::LIMIT_W-1:0]  ratio,
	input  wire logic [mcfp_pkg::LIMIT_W-1:0]  limit,
	input  wire logic                          reverse,
	output logic      [mcfp_pkg::AW-1:0]       a,
	output logic      [mcfp_pkg::HW-1:0]       h
);
	logic signed [63:0] p_s1, p_s2, p_s3;
	logic signed [63:0] lq;
	logic        [63:0] sum;
	logic        [mcfp_pkg::AW-1:0] a_s4;

	assign lq  = $signed({17'b0, limit, 16'b0});
	assign h   = {limit, 16'b0};
	assign sum = 64'(p_s3 + lq);
	assign a   = a_s4;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1 <= $signed(value) * $signed({1'b0, ratio});
		end
		if (en[1]) begin
			p_s2 <= reverse ? -p_s1 : p_s1;
		end
		if (en[2]) begin
			priority if (p_s2 > lq) begin
				p_s3 <= lq;
			end else if (p_s2 < -lq) begin
				p_s3 <= -lq;
			end else begin
				p_s3 <= p_s2;
			end
		end
		if (en[3]) begin
			a_s4 <= sum[mcfp_pkg::AW-1:0];
		end
	end
endmodule
`default_nettype wire

### src/mcfp_gain_front.sv
// Front end for a gain lane: clamp to [0, limit] and double.
// Uses mcfp_pkg. Four register stages to match the signed lanes.
`default_nettype none
module mcfp_gain_front (
	input  wire logic                          clk,
	input  wire logic [3:0]                    en,
	input  wire logic [mcfp_pkg::CMD_W-1:0]    value,
	input  wire logic [mcfp_pkg::LIMIT_W-1:0]  limit,
	output logic      [mcfp_pkg::AW-1:0]       a,
	output logic      [mcfp_pkg::HW-1:0]       h
);
	logic [mcfp_pkg::LIMIT_W-1:0] g_s1, g_s2, g_s3;
	logic [mcfp_pkg::AW-1:0]      a_s4;

	assign h = mcfp_pkg::HW'(limit);
	assign a = a_s4;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			// zero or negative gain maps to zero
			priority if (value[31] || value == '0) begin
				g_s1 <= '0;
			end else if (value[30:0] >= limit) begin
				g_s1 <= limit;
			end else begin
				g_s1 <= value[30:0];
			end
		end
		if (en[1]) begin
			g_s2 <= g_s1;
		end
		if (en[2]) begin
			g_s3 <= g_s2;
		end
		if (en[3]) begin
			a_s4 <= {16'b0, g_s3, 1'b0};
		end
	end
endmodule
`default_nettype wire

### src/mcfp_div.sv
// Pipelined restoring divider: q = (a * (2^MB - 1) + h) / (2 * h), one bit a stage.
// Uses mcfp_pkg. QB + 1 register stages.
`default_nettype none
module mcfp_div #(
	parameter int QB = 16,
	parameter int MB = 16
) (
	input  wire logic                     clk,
	input  wire logic [QB:0]              en,
	input  wire logic [mcfp_pkg::AW-1:0]  a,
	input  wire logic [mcfp_pkg::HW-1:0]  h,
	output logic      [QB-1:0]            q
);
	localparam int NW = mcfp_pkg::HW + 2 + QB;

	logic [NW-1:0] rem_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];

	// dividend scales by the field maximum 2^MB - 1; the quotient never exceeds it
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= (NW'(a) << MB) - NW'(a) + NW'(h);
			quo_s[0] <= '0;
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_bit
		localparam int B = QB - i;
		logic [NW-1:0] dsh;
		logic [QB-1:0] qset;
		always_comb begin
			dsh     = NW'(h) << (B + 1);
			qset    = quo_s[i-1];
			qset[B] = 1'b1;
		end
		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (rem_s[i-1] >= dsh) begin
					rem_s[i] <= rem_s[i-1] - dsh;
					quo_s[i] <= qset;
				end else begin
					rem_s[i] <= rem_s[i-1];
					quo_s[i] <= quo_s[i-1];
				end
			end
		end
	end

	assign q = quo_s[QB];
endmodule
`default_nettype wire

### src/mit_command_frame_packer.sv
// Top level of the MIT-mode command frame packer.
// Uses mcfp_pkg, mcfp_sgn_front, mcfp_gain_front, mcfp_div and the assertion header.
//
// Takes one motor command per cycle unless output back-pressure fills the pipeline,
// and returns one 8-byte frame per command, in order. The pipeline has four front-end
// stages (gear multiply, reverse, clamp, offset on the signed lanes), one stage that
// forms the dividend, then a restoring divider resolving one quotient bit per stage.
// Each stage holds its own valid bit and stalls only when full and blocked downstream,
// so bubbles are squeezed out and a waiting frame does not stop new commands entering.
// A limit or gear ratio written as zero behaves as its reset value. Write configuration
// only while the pipeline is empty.
`default_nettype none
`include "mit_command_frame_packer_assert.svh"
module mit_command_frame_packer #(
	parameter int POSITION_FIELD_BITS = 16,
	parameter int NARROW_FIELD_BITS   = 12
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// target_position, target_velocity, stiffness_gain, damping_gain, feedforward_torque
	input  wire logic [159:0] s_tdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// frame
	output logic [63:0]       m_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire logic         cfg_we,
	input  wire logic [mcfp_pkg::INDEX_W-1:0] cfg_index,
	input  wire logic [mcfp_pkg::LIMIT_W-1:0] cfg_data
);
	localparam int QB = (POSITION_FIELD_BITS > NARROW_FIELD_BITS) ?
		POSITION_FIELD_BITS : NARROW_FIELD_BITS;
	localparam int NS = 5 + QB;

	logic [mcfp_pkg::LIMIT_W-1:0] pos_lim_q, vel_lim_q, tor_lim_q;
	logic [mcfp_pkg::LIMIT_W-1:0] kp_lim_q, kd_lim_q, ratio_q;
	logic                         reverse_q;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	logic [mcfp_pkg::AW-1:0] a_pos, a_vel, a_kp, a_kd, a_tor;
	logic [mcfp_pkg::HW-1:0] h_pos, h_vel, h_kp, h_kd, h_tor;
	logic [QB-1:0]           q_pos, q_vel, q_kp, q_kd, q_tor;

	// Configuration: store the effective value, so a zero write falls back to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_lim_q <= mcfp_pkg::RST_POSITION_LIMIT;
			vel_lim_q <= mcfp_pkg::RST_VELOCITY_LIMIT;
			tor_lim_q <= mcfp_pkg::RST_TORQUE_LIMIT;
			kp_lim_q  <= mcfp_pkg::RST_STIFFNESS_LIMIT;
			kd_lim_q  <= mcfp_pkg::RST_DAMPING_LIMIT;
			ratio_q   <= mcfp_pkg::RST_GEAR_RATIO;
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcfp_pkg::REG_POSITION_LIMIT: pos_lim_q <= (cfg_data == '0) ?
					mcfp_pkg::RST_POSITION_LIMIT : cfg_data;
				mcfp_pkg::REG_VELOCITY_LIMIT: vel_lim_q <= (cfg_data == '0) ?
					mcfp_pkg::RST_VELOCITY_LIMIT : cfg_data;
				mcfp_pkg::REG_TORQUE_LIMIT: tor_lim_q <= (cfg_data == '0) ?
					mcfp_pkg::RST_TORQUE_LIMIT : cfg_data;
				mcfp_pkg::REG_STIFFNESS_LIMIT: kp_lim_q <= (cfg_data == '0) ?
					mcfp_pkg::RST_STIFFNESS_LIMIT : cfg_data;
				mcfp_pkg::REG_DAMPING_LIMIT: kd_lim_q <= (cfg_data == '0) ?
					mcfp_pkg::RST_DAMPING_LIMIT : cfg_data;
				mcfp_pkg::REG_GEAR_RATIO: ratio_q <= (cfg_data == '0) ?
					mcfp_pkg::RST_GEAR_RATIO : cfg_data;
				mcfp_pkg::REG_REVERSE: reverse_q <= cfg_data[0];
				default: ; // unknown index: drop the write
			endcase
		end
	end

	// Stage k loads when it is empty or its contents move on this cycle.
	always_comb begin
		en[NS-1] = !vld_s[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_s[NS-1];

	// Five lanes advance in lockstep on the shared enables.
	mcfp_sgn_front u_pos_front (
		.clk(clk), .en(en[3:0]), .value(s_tdata[31:0]), .ratio(ratio_q),
		.limit(pos_lim_q), .reverse(reverse_q), .a(a_pos), .h(h_pos)
	);
	mcfp_sgn_front u_vel_front (
		.clk(clk), .en(en[3:0]), .value(s_tdata[63:32]), .ratio(ratio_q),
		.limit(vel_lim_q), .reverse(reverse_q), .a(a_vel), .h(h_vel)
	);
	mcfp_gain_front u_kp_front (
		.clk(clk), .en(en[3:0]), .value(s_tdata[95:64]), .limit(kp_lim_q),
		.a(a_kp), .h(h_kp)
	);
	mcfp_gain_front u_kd_front (
		.clk(clk), .en(en[3:0]), .value(s_tdata[127:96]), .limit(kd_lim_q),
		.a(a_kd), .h(h_kd)
	);
	// torque is not geared: unity ratio
	mcfp_sgn_front u_tor_front (
		.clk(clk), .en(en[3:0]), .value(s_tdata[159:128]), .ratio(mcfp_pkg::UNITY_RATIO),
		.limit(tor_lim_q), .reverse(reverse_q), .a(a_tor), .h(h_tor)
	);

	// All dividers share the stage count; each scales by its own field maximum.
	mcfp_div #(.QB(QB), .MB(POSITION_FIELD_BITS)) u_pos_div (
		.clk(clk), .en(en[NS-1:4]), .a(a_pos), .h(h_pos), .q(q_pos)
	);
	mcfp_div #(.QB(QB), .MB(NARROW_FIELD_BITS)) u_vel_div (
		.clk(clk), .en(en[NS-1:4]), .a(a_vel), .h(h_vel), .q(q_vel)
	);
	mcfp_div #(.QB(QB), .MB(NARROW_FIELD_BITS)) u_kp_div (
		.clk(clk), .en(en[NS-1:4]), .a(a_kp), .h(h_kp), .q(q_kp)
	);
	mcfp_div #(.QB(QB), .MB(NARROW_FIELD_BITS)) u_kd_div (
		.clk(clk), .en(en[NS-1:4]), .a(a_kd), .h(h_kd), .q(q_kd)
	);
	mcfp_div #(.QB(QB), .MB(NARROW_FIELD_BITS)) u_tor_div (
		.clk(clk), .en(en[NS-1:4]), .a(a_tor), .h(h_tor), .q(q_tor)
	);

	// Pack big-endian; each value sits in the low bits of its slot.
	assign m_tdata = {
		16'(q_pos[POSITION_FIELD_BITS-1:0]),
		12'(q_vel[NARROW_FIELD_BITS-1:0]),
		12'(q_kp[NARROW_FIELD_BITS-1:0]),
		12'(q_kd[NARROW_FIELD_BITS-1:0]),
		12'(q_tor[NARROW_FIELD_BITS-1:0])
	};

	`MCFP_ASSERT_IMP(a_ready_when_empty, !vld_s[0], s_tready, "empty entry stage refused a command")
	`MCFP_ASSERT_IMP(a_drain_frees_last, m_tvalid && m_tready, en[NS-1], "last stage not freed on drain")
	`MCFP_ASSERT_NXT(a_entry_holds, vld_s[0] && !en[0], vld_s[0], "blocked entry stage lost its command")
endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking bench for mit_command_frame_packer: streams motor commands and
// checks every frame against a bit-exact fixed-point predictor. Depends on mcfp_pkg.
`default_nettype none
module tb;
	localparam int POS_BITS = 16;
	localparam int NAR_BITS = 12;
	localparam int WD_LIMIT = 5000;   // cycles without a transaction while work is pending
	localparam int DRAIN_CYCLES = 40; // comfortably past the pipeline depth

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [159:0] s_tdata = '0;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [mcfp_pkg::INDEX_W-1:0] cfg_index = mcfp_pkg::REG_POSITION_LIMIT;
	logic [mcfp_pkg::LIMIT_W-1:0] cfg_data = '0;

	// bench copy of the register file, indexed like the block
	logic [mcfp_pkg::LIMIT_W-1:0] reg_copy [0:6];

	logic [159:0] cmd_q [$];
	logic [63:0] frame_q [$];
	int src_idle = 0;
	int snk_idle = 0;
	int errors = 0;
	int wd_count = 0;

	mit_command_frame_packer #(
		.POSITION_FIELD_BITS(POS_BITS),
		.NARROW_FIELD_BITS(NAR_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// A zero register falls back to its reset value.
	function automatic logic [mcfp_pkg::LIMIT_W-1:0] eff_reg(logic [mcfp_pkg::LIMIT_W-1:0] r,
			logic [mcfp_pkg::LIMIT_W-1:0] dflt);
		return (r == '0) ? dflt : r;
	endfunction

	// Scale by ratio, optionally negate, clamp to +/-lim and map onto [0, max].
	function automatic logic [15:0] map_signed(logic signed [31:0] v,
			logic [mcfp_pkg::LIMIT_W-1:0] ratio, logic [mcfp_pkg::LIMIT_W-1:0] lim, int bits);
		logic signed [127:0] vv, rr, p, lq;
		logic [127:0] u, r, mx;
		vv = v;
		rr = {1'b0, ratio};
		p = vv * rr;
		lq = {lim, 16'b0};
		mx = (128'd1 << bits) - 1;
		if (reg_copy[mcfp_pkg::REG_REVERSE][0])
			p = -p;
		if (p > lq)
			p = lq;
		if (p < -lq)
			p = -lq;
		u = p + lq;
		r = (u * mx + 128'(lq)) / (128'(lq) * 2);
		if (r > mx)
			r = mx;
		return r[15:0];
	endfunction

	// Map a gain onto [0, max] over [0, lim]; zero or negative gives zero.
	function automatic logic [11:0] map_gain(logic signed [31:0] g,
			logic [mcfp_pkg::LIMIT_W-1:0] lim);
		logic [127:0] r, mx;
		mx = (128'd1 << NAR_BITS) - 1;
		if (g <= 0)
			return '0;
		r = (128'(g) * mx * 2 + 128'(lim)) / (128'(lim) * 2);
		if (r > mx)
			r = mx;
		return r[11:0];
	endfunction

	function automatic logic [63:0] pack_frame(logic [159:0] cmd);
		logic [mcfp_pkg::LIMIT_W-1:0] ratio;
		logic [15:0] pos;
		logic [15:0] vel, tor;
		logic [11:0] kp, kd;
		ratio = eff_reg(reg_copy[mcfp_pkg::REG_GEAR_RATIO], mcfp_pkg::RST_GEAR_RATIO);
		pos = map_signed(cmd[31:0], ratio,
			eff_reg(reg_copy[mcfp_pkg::REG_POSITION_LIMIT], mcfp_pkg::RST_POSITION_LIMIT),
			POS_BITS);
		vel = map_signed(cmd[63:32], ratio,
			eff_reg(reg_copy[mcfp_pkg::REG_VELOCITY_LIMIT], mcfp_pkg::RST_VELOCITY_LIMIT),
			NAR_BITS);
		kp = map_gain(cmd[95:64], eff_reg(reg_copy[mcfp_pkg::REG_STIFFNESS_LIMIT],
			mcfp_pkg::RST_STIFFNESS_LIMIT));
		kd = map_gain(cmd[127:96], eff_reg(reg_copy[mcfp_pkg::REG_DAMPING_LIMIT],
			mcfp_pkg::RST_DAMPING_LIMIT));
		tor = map_signed(cmd[159:128], mcfp_pkg::UNITY_RATIO,
			eff_reg(reg_copy[mcfp_pkg::REG_TORQUE_LIMIT], mcfp_pkg::RST_TORQUE_LIMIT),
			NAR_BITS);
		return {pos, vel[11:0], kp, kd, tor[11:0]};
	endfunction

	task automatic report(string field, logic [15:0] got, logic [15:0] want);
		if (got !== want) begin
			$display("frame mismatch on %s: got %h, want %h", field, got, want);
			errors++;
		end
	endtask

	// Driver: advance to the next pending command whenever the slot is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				frame_q.push_back(pack_frame(s_tdata));
			if (cmd_q.size() > 0 && $urandom_range(99) >= src_idle) begin
				s_tdata <= cmd_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each frame transaction field by field against the oldest prediction.
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frame_q.size() == 0) begin
					$display("unexpected frame %h", m_tdata);
					errors++;
				end else begin
					want = frame_q.pop_front();
					report("position", m_tdata[63:48], want[63:48]);
					report("velocity", m_tdata[47:36], want[47:36]);
					report("kp", m_tdata[35:24], want[35:24]);
					report("kd", m_tdata[23:12], want[23:12]);
					report("torque", m_tdata[11:0], want[11:0]);
				end
			end
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// Watchdog: count stalled cycles only while something is still in flight.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cmd_q.size() == 0 && !s_tvalid && frame_q.size() == 0))
				wd_count <= 0;
			else
				wd_count <= wd_count + 1;
			if (wd_count >= WD_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic cfg_write(logic [mcfp_pkg::INDEX_W-1:0] idx,
			logic [mcfp_pkg::LIMIT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		// unknown indexes leave the register file alone
		if (idx <= mcfp_pkg::REG_REVERSE)
			reg_copy[idx] = (idx == mcfp_pkg::REG_REVERSE) ? {30'b0, val[0]} : val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until the pipeline is empty, then let it settle.
	task automatic drain();
		while (cmd_q.size() > 0 || s_tvalid || frame_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input limit that lands near the register limit after the gear ratio.
	function automatic logic [31:0] near_limit(logic [mcfp_pkg::LIMIT_W-1:0] lim,
			logic [mcfp_pkg::LIMIT_W-1:0] ratio);
		logic [63:0] s;
		s = ({33'b0, lim} << 16) / {33'b0, ratio};
		return (s > 64'h3FFF_FFFF) ? 32'h3FFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] rand_word(logic [31:0] span);
		logic [31:0] pick [5];
		pick = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3, 4, 5, 6: return $urandom_range(0, 2 * span) - span;
			7: return pick[$urandom_range(4)];
			default: return ($urandom_range(1) ? span : -span) + $urandom_range(4) - 2;
		endcase
	endfunction

	function automatic logic [159:0] rand_cmd();
		logic [mcfp_pkg::LIMIT_W-1:0] ratio;
		ratio = eff_reg(reg_copy[mcfp_pkg::REG_GEAR_RATIO], mcfp_pkg::RST_GEAR_RATIO);
		return {
			rand_word(near_limit(eff_reg(reg_copy[mcfp_pkg::REG_TORQUE_LIMIT],
				mcfp_pkg::RST_TORQUE_LIMIT), mcfp_pkg::UNITY_RATIO)),
			rand_word({1'b0, eff_reg(reg_copy[mcfp_pkg::REG_DAMPING_LIMIT],
				mcfp_pkg::RST_DAMPING_LIMIT)}),
			rand_word({1'b0, eff_reg(reg_copy[mcfp_pkg::REG_STIFFNESS_LIMIT],
				mcfp_pkg::RST_STIFFNESS_LIMIT)}),
			rand_word(near_limit(eff_reg(reg_copy[mcfp_pkg::REG_VELOCITY_LIMIT],
				mcfp_pkg::RST_VELOCITY_LIMIT), ratio)),
			rand_word(near_limit(eff_reg(reg_copy[mcfp_pkg::REG_POSITION_LIMIT],
				mcfp_pkg::RST_POSITION_LIMIT), ratio))};
	endfunction

	function automatic logic [mcfp_pkg::LIMIT_W-1:0] rand_reg();
		case ($urandom_range(3))
			0: return mcfp_pkg::LIMIT_W'($urandom);
			1: return mcfp_pkg::LIMIT_W'($urandom_range(1, 1 << 12));
			default: return mcfp_pkg::LIMIT_W'($urandom_range(1 << 12, 1 << 26));
		endcase
	endfunction

	initial begin
		int idle_src [4];
		int idle_snk [4];
		idle_src = '{0, 58, 0, 37};
		idle_snk = '{0, 0, 58, 37};
		reg_copy[mcfp_pkg::REG_POSITION_LIMIT] = mcfp_pkg::RST_POSITION_LIMIT;
		reg_copy[mcfp_pkg::REG_VELOCITY_LIMIT] = mcfp_pkg::RST_VELOCITY_LIMIT;
		reg_copy[mcfp_pkg::REG_TORQUE_LIMIT] = mcfp_pkg::RST_TORQUE_LIMIT;
		reg_copy[mcfp_pkg::REG_STIFFNESS_LIMIT] = mcfp_pkg::RST_STIFFNESS_LIMIT;
		reg_copy[mcfp_pkg::REG_DAMPING_LIMIT] = mcfp_pkg::RST_DAMPING_LIMIT;
		reg_copy[mcfp_pkg::REG_GEAR_RATIO] = mcfp_pkg::RST_GEAR_RATIO;
		reg_copy[mcfp_pkg::REG_REVERSE] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, exact limits and rounding points at reset settings.
		cmd_q.push_back('0);
		cmd_q.push_back({5{32'h7FFF_FFFF}});
		cmd_q.push_back({5{32'h8000_0000}});
		cmd_q.push_back({5{32'hFFFF_FFFF}});
		cmd_q.push_back({5{32'h0000_0001}});
		cmd_q.push_back({32'd655360, 32'd327680, 32'd32768000, 32'd1966080, 32'd819200});
		cmd_q.push_back({-32'sd655360, 32'd327681, 32'd32768001, -32'sd1966080, -32'sd819200});
		cmd_q.push_back({32'd655361, 32'd163840, 32'd16384000, 32'd1966081, 32'd819201});
		cmd_q.push_back({-32'sd655361, 32'd40, 32'd4000, -32'sd1966081, -32'sd819201});
		cmd_q.push_back({32'd80, 32'd41, 32'd4001, 32'd240, 32'd6});
		cmd_q.push_back({-32'sd80, 32'd39, 32'd3999, -32'sd240, -32'sd6});
		cmd_q.push_back({32'd160, 32'd120, 32'd12000, 32'd480, 32'd12});
		drain();

		// Extremes: every register at its minimum, reversed.
		for (int i = 0; i <= 5; i++)
			cfg_write(i[mcfp_pkg::INDEX_W-1:0], 31'd1);
		cfg_write(mcfp_pkg::REG_REVERSE, 31'd1);
		for (int i = 0; i < 12; i++)
			cmd_q.push_back(rand_cmd());
		drain();

		// Random phases: rotate the idling mode and the register settings.
		for (int ph = 0; ph < 8; ph++) begin
			src_idle = idle_src[ph % 4];
			snk_idle = idle_snk[ph % 4];
			case (ph)
				0: begin
					for (int i = 0; i <= 5; i++)
						cfg_write(i[mcfp_pkg::INDEX_W-1:0], 31'h7FFF_FFFF);
					cfg_write(mcfp_pkg::REG_REVERSE, 31'd0);
				end
				1: begin
					// zero registers fall back to reset values; index 7 is ignored
					for (int i = 0; i <= 5; i++)
						cfg_write(i[mcfp_pkg::INDEX_W-1:0], 31'd0);
					cfg_write(mcfp_pkg::REG_REVERSE, 31'h7FFF_FFFE);
					cfg_write(3'd7, 31'd5);
				end
				2: begin
					cfg_write(mcfp_pkg::REG_POSITION_LIMIT, mcfp_pkg::RST_POSITION_LIMIT);
					cfg_write(mcfp_pkg::REG_VELOCITY_LIMIT, mcfp_pkg::RST_VELOCITY_LIMIT);
					cfg_write(mcfp_pkg::REG_TORQUE_LIMIT, mcfp_pkg::RST_TORQUE_LIMIT);
					cfg_write(mcfp_pkg::REG_STIFFNESS_LIMIT, mcfp_pkg::RST_STIFFNESS_LIMIT);
					cfg_write(mcfp_pkg::REG_DAMPING_LIMIT, mcfp_pkg::RST_DAMPING_LIMIT);
					cfg_write(mcfp_pkg::REG_GEAR_RATIO, 31'd589824);
					cfg_write(mcfp_pkg::REG_REVERSE, 31'd1);
				end
				default: begin
					for (int i = 0; i <= 5; i++)
						cfg_write(i[mcfp_pkg::INDEX_W-1:0], rand_reg());
					cfg_write(mcfp_pkg::REG_REVERSE, mcfp_pkg::LIMIT_W'($urandom));
				end
			endcase
			for (int i = 0; i < 70; i++)
				cmd_q.push_back(rand_cmd());
			// once, stop sending until every outstanding frame has returned
			if (ph == 5) begin
				while (cmd_q.size() > 0 || s_tvalid || frame_q.size() > 0)
					@(posedge clk);
			end
			for (int i = 0; i < 70; i++)
				cmd_q.push_back(rand_cmd());
			drain();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+src
src/mcfp_pkg.sv
src/mcfp_sgn_front.sv
src/mcfp_gain_front.sv
src/mcfp_div.sv
src/mit_command_frame_packer.sv
tb/sv/tb.sv
